### rtl/response_record_deframer_macros.svh
// Assertion helpers shared by the deframer modules.
`ifndef RESPONSE_RECORD_DEFRAMER_MACROS_SVH
`define RESPONSE_RECORD_DEFRAMER_MACROS_SVH

// Checks a property on every rising edge while reset is released.
`define RRD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks a property on every rising edge, reset included.
`define RRD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/rrd_pkg.sv
package rrd_pkg;

	// Parser phase codes.
	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_CONTENT = 2'd1;
	localparam logic [1:0] PH_PADDING = 2'd2;

	// Record type codes of interest.
	localparam logic [7:0] TYPE_END = 8'd3;
	localparam logic [7:0] TYPE_OUT = 8'd6;
	localparam logic [7:0] TYPE_ERR = 8'd7;

	// Result kind codes.
	localparam logic [1:0] KIND_STDOUT = 2'd0;
	localparam logic [1:0] KIND_STDERR = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;

	// Header byte positions.
	localparam logic [2:0] HDR_TYPE     = 3'd1;
	localparam logic [2:0] HDR_OWNER_HI = 3'd2;
	localparam logic [2:0] HDR_OWNER_LO = 3'd3;
	localparam logic [2:0] HDR_LEN_HI   = 3'd4;
	localparam logic [2:0] HDR_LEN_LO   = 3'd5;
	localparam logic [2:0] HDR_PAD      = 3'd6;
	localparam logic [2:0] HDR_LAST     = 3'd7;

	// Register addresses (word index).
	localparam logic REG_REQUEST_ID = 1'b0;

	localparam logic [15:0] REQUEST_ID_RESET = 16'd1;

	// One result word.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [31:0] stdout_total;
		logic [31:0] stderr_total;
	} rrd_result_t;

endpackage

### rtl/rrd_parser.sv
`include "response_record_deframer_macros.svh"

module rrd_parser #(
	parameter int TOTAL_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          in_byte,
	input  logic [15:0]         request_id,
	output logic                push,
	output rrd_pkg::rrd_result_t result
);
	import rrd_pkg::*;

	logic [1:0]            phase_q, phase_d;
	logic [2:0]            header_index_q, header_index_d;
	logic [7:0]            record_type_q, record_type_d;
	logic [15:0]           record_owner_q, record_owner_d;
	logic [15:0]           content_left_q, content_left_d;
	logic [7:0]            padding_left_q, padding_left_d;
	logic [TOTAL_BITS-1:0] out_count_q, out_count_d;
	logic [TOTAL_BITS-1:0] err_count_q, err_count_d;
	logic [TOTAL_BITS-1:0] out_inc, err_inc;
	logic                  owned;
	logic                  push_d;
	rrd_result_t           res_d;
	logic                  in_header;
	logic                  done_push;
	logic                  totals_zero;

	// Saturating increments of both totals.
	assign out_inc = (out_count_q == '1) ? out_count_q : out_count_q + TOTAL_BITS'(1);
	assign err_inc = (err_count_q == '1) ? err_count_q : err_count_q + TOTAL_BITS'(1);
	assign owned   = (record_owner_q == request_id);

	// Next state and result for the byte on the input.
	always_comb begin
		phase_d        = phase_q;
		header_index_d = header_index_q;
		record_type_d  = record_type_q;
		record_owner_d = record_owner_q;
		content_left_d = content_left_q;
		padding_left_d = padding_left_q;
		out_count_d    = out_count_q;
		err_count_d    = err_count_q;
		push_d         = 1'b0;
		res_d.kind         = KIND_DONE;
		res_d.data_byte    = 8'd0;
		res_d.stdout_total = 32'(out_count_q);
		res_d.stderr_total = 32'(err_count_q);
		case (phase_q)
			PH_CONTENT: begin
				content_left_d = content_left_q - 16'd1;
				if (owned && record_type_q == TYPE_OUT) begin
					out_count_d        = out_inc;
					push_d             = 1'b1;
					res_d.kind         = KIND_STDOUT;
					res_d.data_byte    = in_byte;
					res_d.stdout_total = 32'(out_inc);
				end else if (owned && record_type_q == TYPE_ERR) begin
					err_count_d        = err_inc;
					push_d             = 1'b1;
					res_d.kind         = KIND_STDERR;
					res_d.data_byte    = in_byte;
					res_d.stderr_total = 32'(err_inc);
				end
				if (content_left_d == 16'd0) begin
					if (!push_d && owned && record_type_q == TYPE_END) begin
						push_d      = 1'b1;
						out_count_d = '0;
						err_count_d = '0;
					end
					phase_d = (padding_left_q != 8'd0) ? PH_PADDING : PH_HEADER;
				end
			end
			PH_PADDING: begin
				padding_left_d = padding_left_q - 8'd1;
				if (padding_left_d == 8'd0) begin
					phase_d = PH_HEADER;
				end
			end
			default: begin
				// Header phase; the unused code behaves the same way.
				phase_d = PH_HEADER;
				case (header_index_q)
					HDR_TYPE:     record_type_d = in_byte;
					HDR_OWNER_HI: record_owner_d[15:8] = in_byte;
					HDR_OWNER_LO: record_owner_d[7:0] = in_byte;
					HDR_LEN_HI:   content_left_d[15:8] = in_byte;
					HDR_LEN_LO:   content_left_d[7:0] = in_byte;
					HDR_PAD:      padding_left_d = in_byte;
					default:      ;
				endcase
				if (header_index_q == HDR_LAST) begin
					header_index_d = 3'd0;
					if (content_left_d != 16'd0) begin
						phase_d = PH_CONTENT;
					end else begin
						// An empty end-request record completes right here.
						if (record_type_d == TYPE_END && record_owner_d == request_id) begin
							push_d      = 1'b1;
							out_count_d = '0;
							err_count_d = '0;
						end
						phase_d = (padding_left_d != 8'd0) ? PH_PADDING : PH_HEADER;
					end
				end else begin
					header_index_d = header_index_q + 3'd1;
				end
			end
		endcase
	end

	assign push   = accept && push_d;
	assign result = res_d;

	// State registers advance on each accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEADER;
			header_index_q <= 3'd0;
			record_type_q  <= 8'd0;
			record_owner_q <= 16'd0;
			content_left_q <= 16'd0;
			padding_left_q <= 8'd0;
			out_count_q    <= '0;
			err_count_q    <= '0;
		end else if (accept) begin
			phase_q        <= phase_d;
			header_index_q <= header_index_d;
			record_type_q  <= record_type_d;
			record_owner_q <= record_owner_d;
			content_left_q <= content_left_d;
			padding_left_q <= padding_left_d;
			out_count_q    <= out_count_d;
			err_count_q    <= err_count_d;
		end
	end

	// Terms used by the checks below.
	assign in_header   = (phase_q == PH_HEADER);
	assign done_push   = push && (res_d.kind == KIND_DONE);
	assign totals_zero = (out_count_q == '0) && (err_count_q == '0);

	// The header counter only moves during the header phase.
	`RRD_ASSERT(a_index_in_header, !in_header |-> (header_index_q == 3'd0), "stray header index")
	// A completion clears both totals.
	`RRD_ASSERT(a_done_clears, done_push |=> totals_zero, "totals not cleared after completion")
	// The content phase always has bytes left to take.
	`RRD_ASSERT(a_content_left, (phase_q == PH_CONTENT) |-> |content_left_q, "empty content phase")
	// The padding phase always has bytes left to skip.
	`RRD_ASSERT(a_pad_left, (phase_q == PH_PADDING) |-> |padding_left_q, "empty padding phase")

endmodule

### rtl/rrd_skid.sv
`include "response_record_deframer_macros.svh"

module rrd_skid (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rrd_pkg::rrd_result_t wdata,
	output logic                can_accept,
	output logic                out_valid,
	input  logic                out_ready,
	output rrd_pkg::rrd_result_t rdata
);
	import rrd_pkg::*;

	logic        out_valid_q;
	logic        skid_valid_q;
	rrd_result_t out_q;
	rrd_result_t skid_q;
	logic        pop;
	logic        stall;

	assign pop        = out_valid_q && out_ready;
	assign stall      = out_valid_q && !out_ready;
	assign can_accept = !skid_valid_q;
	assign out_valid  = out_valid_q;
	assign rdata      = out_q;

	// Control: output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_q <= wdata;
			end else begin
				skid_q <= wdata;
			end
		end
	end

	// The skid entry is only used behind a full output register.
	`RRD_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid without output")
	// A word arriving at a stalled full output goes to the skid entry.
	`RRD_ASSERT(a_skid_fill, (stall && push) |=> skid_valid_q, "stalled word was dropped")
	// A stalled output word stays in place until it is taken.
	`RRD_ASSERT(a_out_hold, stall |=> (out_valid_q && $stable(out_q)), "stalled word changed")

endmodule

### rtl/response_record_deframer.sv
// Response record deframer.
// Input channel: one byte of the response record stream per word (in_byte,
// in_valid, in_ready). Each record is an 8-byte header, content and padding.
// Output channel: one result word (kind, data_byte, stdout_total,
// stderr_total, out_valid, out_ready) for every stdout or stderr content byte
// of the configured request id, and one completion word when that id's
// end-request record finishes; totals are then cleared.
// Configuration: request_id at byte address 0 over the APB port; write it
// only while the block is idle. Reset value is 1.
// Parser state and results are registered when their byte is accepted.
// Throughput: one byte per cycle while in_ready is high.
// Stall: the output register has one skid entry behind it that holds one more
// result while one waits; in_ready drops only when the skid entry is full.
// Reset: asynchronous; clears the parser to the start of a header, both totals
// and the output buffer, and sets request_id to 1.
module response_record_deframer #(
	parameter int TOTAL_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [31:0] stdout_total,
	output logic [31:0] stderr_total,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import rrd_pkg::*;

	logic        reg_sel;
	logic [15:0] req_id_q;
	logic        accept;
	logic        push;
	logic        can_accept;
	rrd_result_t result;
	rrd_result_t rdata;

	// Configuration register.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_id_q <= REQUEST_ID_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_REQUEST_ID) begin
			req_id_q <= pwdata[15:0];
		end
	end
	assign reg_sel = (paddr[2] == REG_REQUEST_ID);
	assign prdata  = reg_sel ? {16'd0, req_id_q} : 32'd0;

	assign in_ready = can_accept;
	assign accept   = in_valid && can_accept;

	rrd_parser #(
		.TOTAL_BITS(TOTAL_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (in_byte),
		.request_id(req_id_q),
		.push      (push),
		.result    (result)
	);

	rrd_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (result),
		.can_accept(can_accept),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.rdata     (rdata)
	);

	assign kind         = rdata.kind;
	assign data_byte    = rdata.data_byte;
	assign stdout_total = rdata.stdout_total;
	assign stderr_total = rdata.stderr_total;

endmodule

### bench/tb_response_record_deframer.sv
`timescale 1ns / 1ps

module tb_response_record_deframer;
	import rrd_pkg::*;

	localparam int TOTAL_BITS = 32;
	localparam logic [63:0] TOTAL_MAX = {64{1'b1}} >> (64 - TOTAL_BITS);
	localparam int CYCLE_LIMIT = 1000000;
	localparam int WORDS_PER_PHASE = 90;
	localparam logic [2:0] REQUEST_ID_ADDR = {REG_REQUEST_ID, 2'b00};

	// One row of the opening stimulus; want is used only where typed is set.
	typedef struct packed {
		logic [7:0]  b;
		bit          typed;
		rrd_result_t want;
	} stim_row_t;

	// Three records right after reset: stdout with padding and extreme
	// version and reserved bytes, stderr, and an end-request with no content.
	localparam stim_row_t OPENING_ROWS [28] = '{
		'{8'hFF, 1'b0, '0}, '{TYPE_OUT, 1'b0, '0}, '{8'h00, 1'b0, '0},
		'{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h02, 1'b0, '0},
		'{8'h01, 1'b0, '0}, '{8'hFF, 1'b0, '0},
		'{8'h00, 1'b1, '{KIND_STDOUT, 8'h00, 32'd1, 32'd0}},
		'{8'hFF, 1'b1, '{KIND_STDOUT, 8'hFF, 32'd2, 32'd0}},
		'{8'hAA, 1'b0, '0},
		'{8'h00, 1'b0, '0}, '{TYPE_ERR, 1'b0, '0}, '{8'h00, 1'b0, '0},
		'{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0},
		'{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
		'{8'h80, 1'b1, '{KIND_STDERR, 8'h80, 32'd2, 32'd1}},
		'{8'h01, 1'b0, '0}, '{TYPE_END, 1'b0, '0}, '{8'h00, 1'b0, '0},
		'{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h7F, 1'b1, '{KIND_DONE, 8'h00, 32'd2, 32'd1}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [31:0] stdout_total;
	logic [31:0] stderr_total;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	// Parser state as the block should hold it.
	logic [1:0]  parse_phase = PH_HEADER;
	logic [2:0]  hdr_pos = 3'd0;
	logic [7:0]  rec_type = 8'd0;
	logic [15:0] rec_owner = 16'd0;
	logic [15:0] content_left = 16'd0;
	logic [7:0]  pad_left = 8'd0;
	logic [63:0] stdout_count = 64'd0;
	logic [63:0] stderr_count = 64'd0;
	logic [15:0] request_id_cfg = REQUEST_ID_RESET;

	rrd_result_t awaited_words [$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          stall_left = 0;
	bit          tx_calm = 1'b0;
	bit          rx_calm = 1'b0;

	response_record_deframer #(
		.TOTAL_BITS(TOTAL_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.data_byte(data_byte),
		.stdout_total(stdout_total),
		.stderr_total(stderr_total),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Most gaps are short; a few are long.
	function automatic int pick_gap(bit calm);
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		if (r < 99) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic void report_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%s", msg);
		end
	endfunction

	function automatic logic [63:0] bump_total(logic [63:0] v);
		return (v >= TOTAL_MAX) ? TOTAL_MAX : v + 64'd1;
	endfunction

	function automatic rrd_result_t make_word(logic [1:0] k, logic [7:0] d);
		rrd_result_t w;
		w.kind = k;
		w.data_byte = d;
		w.stdout_total = stdout_count[31:0];
		w.stderr_total = stderr_count[31:0];
		return w;
	endfunction

	// A matching end-request record reports the totals, then clears them.
	function automatic bit close_request(output rrd_result_t w);
		w = '0;
		if (rec_type == TYPE_END && rec_owner == request_id_cfg) begin
			w = make_word(KIND_DONE, 8'h00);
			stdout_count = 64'd0;
			stderr_count = 64'd0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advances the parser by one byte and returns whether a word results.
	function automatic bit deframe_byte(logic [7:0] b, output rrd_result_t w);
		bit hit;
		hit = 1'b0;
		w = '0;
		if (parse_phase == PH_CONTENT) begin
			content_left = content_left - 16'd1;
			if (rec_owner == request_id_cfg && rec_type == TYPE_OUT) begin
				stdout_count = bump_total(stdout_count);
				w = make_word(KIND_STDOUT, b);
				hit = 1'b1;
			end else if (rec_owner == request_id_cfg && rec_type == TYPE_ERR) begin
				stderr_count = bump_total(stderr_count);
				w = make_word(KIND_STDERR, b);
				hit = 1'b1;
			end
			if (content_left == 16'd0) begin
				if (!hit) begin
					hit = close_request(w);
				end
				parse_phase = (pad_left != 8'd0) ? PH_PADDING : PH_HEADER;
			end
		end else if (parse_phase == PH_PADDING) begin
			pad_left = pad_left - 8'd1;
			if (pad_left == 8'd0) begin
				parse_phase = PH_HEADER;
			end
		end else begin
			// Header bytes; the unused phase code lands here too.
			parse_phase = PH_HEADER;
			case (hdr_pos)
				HDR_TYPE:     rec_type = b;
				HDR_OWNER_HI: rec_owner[15:8] = b;
				HDR_OWNER_LO: rec_owner[7:0] = b;
				HDR_LEN_HI:   content_left[15:8] = b;
				HDR_LEN_LO:   content_left[7:0] = b;
				HDR_PAD:      pad_left = b;
				default:      ;
			endcase
			if (hdr_pos == HDR_LAST) begin
				hdr_pos = 3'd0;
				if (content_left != 16'd0) begin
					parse_phase = PH_CONTENT;
				end else begin
					hit = close_request(w);
					parse_phase = (pad_left != 8'd0) ? PH_PADDING : PH_HEADER;
				end
			end else begin
				hdr_pos = hdr_pos + 3'd1;
			end
		end
		return hit;
	endfunction

	// Offers one byte, waits for it to be taken, and records what it causes.
	task automatic feed_byte(input logic [7:0] b, input bit typed = 1'b0,
			input rrd_result_t want = '0);
		int gap;
		rrd_result_t w;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (!in_ready);
		if (deframe_byte(b, w) && !typed) begin
			awaited_words.push_back(w);
		end
		if (typed) begin
			awaited_words.push_back(want);
		end
	endtask

	// Holds the sender off until every expected word has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (awaited_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Writes request_id over APB and reads it back.
	task automatic set_request_id(input logic [15:0] id);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REQUEST_ID_ADDR;
		pwdata <= {16'h0000, id};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		request_id_cfg = id;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {16'h0000, id}) begin
			report_mismatch($sformatf("request_id readback: expected %04h, got %08h",
				id, prdata));
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Sends one record with random content and returns how many bytes it took.
	// Most records are well formed and mostly for the configured id; a few
	// have a scrambled header.
	task automatic send_record(output int counted);
		logic [7:0]  hdr [8];
		logic [7:0]  rtype;
		logic [15:0] owner;
		int          len;
		int          pad;
		int          r;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			rtype = TYPE_OUT;
		end else if (r < 65) begin
			rtype = TYPE_ERR;
		end else if (r < 85) begin
			rtype = TYPE_END;
		end else begin
			rtype = 8'($urandom);
		end
		r = $urandom_range(0, 99);
		if (r < 80) begin
			owner = request_id_cfg;
		end else if (r < 90) begin
			owner = request_id_cfg ^ (16'd1 << $urandom_range(0, 15));
		end else begin
			owner = 16'($urandom);
		end
		r = $urandom_range(0, 99);
		if (r < 15) begin
			len = 0;
		end else if (r < 85) begin
			len = $urandom_range(1, 8);
		end else if (r < 97) begin
			len = $urandom_range(9, 40);
		end else begin
			len = $urandom_range(256, 300);
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			pad = 0;
		end else if (r < 95) begin
			pad = $urandom_range(1, 7);
		end else begin
			pad = $urandom_range(200, 255);
		end
		hdr[0] = 8'($urandom);
		hdr[1] = rtype;
		hdr[2] = owner[15:8];
		hdr[3] = owner[7:0];
		hdr[4] = 8'(len >> 8);
		hdr[5] = 8'(len);
		hdr[6] = 8'(pad);
		hdr[7] = 8'($urandom);
		// The scrambled length is kept below 512 bytes to bound the run.
		if ($urandom_range(0, 19) == 0) begin
			foreach (hdr[i]) begin
				hdr[i] = 8'($urandom);
			end
			hdr[4][7:1] = 7'd0;
		end
		len = int'({hdr[4], hdr[5]});
		pad = int'(hdr[6]);
		foreach (hdr[i]) begin
			feed_byte(hdr[i]);
		end
		repeat (len) feed_byte(8'($urandom));
		repeat (pad) feed_byte(8'($urandom));
		counted = 8 + len + pad;
	endtask

	// Compares one accepted word with the oldest expectation.
	function automatic void check_word();
		rrd_result_t want;
		if (awaited_words.size() == 0) begin
			report_mismatch($sformatf("unexpected word: kind %0d data %02h out %0d err %0d",
				kind, data_byte, stdout_total, stderr_total));
			return;
		end
		want = awaited_words.pop_front();
		if (kind !== want.kind || data_byte !== want.data_byte
				|| stdout_total !== want.stdout_total || stderr_total !== want.stderr_total) begin
			report_mismatch({
				$sformatf("word mismatch: expected kind %0d data %02h out %0d err %0d",
					want.kind, want.data_byte, want.stdout_total, want.stderr_total),
				$sformatf(", got kind %0d data %02h out %0d err %0d",
					kind, data_byte, stdout_total, stderr_total)});
		end
	endfunction

	// Output side: check each accepted word, then choose the next ready.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			check_word();
		end
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			stall_left = pick_gap(rx_calm);
			out_ready <= (stall_left == 0);
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL response_record_deframer");
			$finish;
		end
	end

	initial begin
		logic [15:0] phase_ids [4];
		int          phase_words;
		int          counted;
		phase_ids = '{16'hFFFF, 16'h0000, 16'($urandom), 16'h0100};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Opening records at the reset request id.
		foreach (OPENING_ROWS[i]) begin
			feed_byte(OPENING_ROWS[i].b, OPENING_ROWS[i].typed, OPENING_ROWS[i].want);
		end

		// Random records under several request ids; the second phase runs
		// with no random gaps on either side.
		foreach (phase_ids[p]) begin
			wait_drained();
			set_request_id(phase_ids[p]);
			phase_words = 0;
			while (phase_words < WORDS_PER_PHASE) begin
				tx_calm = (p == 1) || ($urandom_range(0, 4) == 0);
				rx_calm = (p == 1) || ($urandom_range(0, 4) == 0);
				if ($urandom_range(0, 39) == 0) begin
					wait_drained();
				end
				send_record(counted);
				phase_words += counted;
			end
		end

		wait_drained();
		if (mismatch_count == 0) begin
			$display("PASS response_record_deframer");
		end else begin
			$display("FAIL response_record_deframer");
		end
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/rrd_pkg.sv
rtl/rrd_parser.sv
rtl/rrd_skid.sv
rtl/response_record_deframer.sv
bench/tb_response_record_deframer.sv
